// File: src/binary_vector_similarity_macros.svh
// Assertion macros for the binary vector similarity checker.
`ifndef BINARY_VECTOR_SIMILARITY_MACROS_SVH
`define BINARY_VECTOR_SIMILARITY_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define BVS_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define BVS_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/bvs_pkg.sv
// Shared types, constants and helper functions of the binary vector similarity block.
`timescale 1ns / 1ps

package bvs_pkg;

   // Field widths of the request and response channels
   localparam int DATA_W  = 64;
   localparam int LEN_W   = 13;
   localparam int RATIO_W = 17;
   localparam int FRAC_W  = 16;

   // Last-word bit count, up to the widest supported word (64)
   localparam int REST_W = 7;

   // Popcount slice handled per cycle
   localparam int CHUNK_W = 8;
   localparam int POP_W   = 4;

   // Register port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] REG_VECTOR_BITS = 1'b0;
   localparam logic [LEN_W-1:0] VECTOR_BITS_RESET = 13'd64;

   // Restoring divider: one quotient bit per step
   localparam int DIV_STEPS = RATIO_W;
   localparam int DIV_CNT_W = 5;

   typedef struct packed {
      logic [DATA_W-1:0] word_a;
      logic [DATA_W-1:0] word_b;
   } req_payload_type;

   typedef struct packed {
      logic [LEN_W-1:0]   match_count;
      logic [LEN_W-1:0]   both_count;
      logic [LEN_W-1:0]   either_count;
      logic [RATIO_W-1:0] jaccard_ratio;
      logic               empty_union;
   } rsp_payload_type;

   // Length information derived from the vector_bits register
   typedef struct packed {
      logic              busy;
      logic [LEN_W-1:0]  len;
      logic [REST_W-1:0] rest;
   } cfg_info_type;

   // Commands from the sequencer to the popcount datapath
   typedef struct packed {
      logic load;
      logic step;
      logic clear;
   } count_ctl_type;

   // Ones in one slice
   function automatic logic [POP_W-1:0] pop_chunk(input logic [CHUNK_W-1:0] v);
      logic [POP_W-1:0] c;
      c = '0;
      for (int i = 0; i < CHUNK_W; i++) begin
         c = c + POP_W'(v[i]);
      end
      return c;
   endfunction

endpackage

// File: src/bvs_cfg.sv
// Register port and derived vector length / last-word bit count.
`timescale 1ns / 1ps

module bvs_cfg
   import bvs_pkg::*;
#(
   parameter int WORD_BITS = 64,
   parameter int MAX_WORDS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_info_type          info
);

   localparam int MAX_LEN  = MAX_WORDS * WORD_BITS;
   // Reciprocal of WORD_BITS, exact for 13-bit numerators
   localparam int SHIFT    = 20;
   localparam int RECIP    = ((1 << SHIFT) + WORD_BITS - 1) / WORD_BITS;

   logic [LEN_W-1:0]   vb_ff, vb_in;
   logic [1:0]         upd_ff, upd_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [LEN_W-1:0]   q_ff, q_in;
   logic [REST_W-1:0]  rest_ff, rest_in;
   logic [31:0]        prod;
   logic [LEN_W-1:0]   lm1;
   logic               wr_en;
   logic [CSR_IDX_W-1:0] idx;

   assign pready = 1'b1;
   assign idx    = paddr[CSR_ADDR_W-1:2];
   assign wr_en  = psel && penable && pwrite && pready && (idx == REG_VECTOR_BITS);

   // Register write
   always_comb begin
      vb_in = vb_ff;
      if (wr_en) begin
         vb_in = pwdata[LEN_W-1:0];
      end
   end

   // Readback
   always_comb begin
      prdata = '0;
      if (idx == REG_VECTOR_BITS) begin
         prdata = CSR_DATA_W'(vb_ff);
      end
   end

   // Stage 1: clamp length, number of full words before the last one
   always_comb begin
      if (vb_ff == '0) begin
         len_in = LEN_W'(1);
      end else if (int'(vb_ff) > MAX_LEN) begin
         len_in = LEN_W'(MAX_LEN);
      end else begin
         len_in = vb_ff;
      end
      lm1  = len_in - LEN_W'(1);
      prod = 32'(lm1) * 32'(RECIP);
      q_in = LEN_W'(prod >> SHIFT);
   end

   // Stage 2: bits in the last word
   assign rest_in = REST_W'(int'(len_ff) - int'(q_ff) * WORD_BITS);

   // Busy covers the settling of the derived length and last-word bit count after a write or reset
   always_comb begin
      upd_in = {upd_ff[0], 1'b0};
      if (wr_en) begin
         upd_in = 2'b11;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff  <= VECTOR_BITS_RESET;
         upd_ff <= 2'b11;
      end else begin
         vb_ff  <= vb_in;
         upd_ff <= upd_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff  <= len_in;
      q_ff    <= q_in;
      rest_ff <= rest_in;
   end

   assign info.busy = |upd_ff;
   assign info.len  = len_ff;
   assign info.rest = rest_ff;

endmodule

// File: src/bvs_count.sv
// Slice-serial popcount datapath with the three running counts.
`timescale 1ns / 1ps

module bvs_count
   import bvs_pkg::*;
#(
   parameter int WORD_BITS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  count_ctl_type        ctl,
   input  logic [DATA_W-1:0]    word_a,
   input  logic [DATA_W-1:0]    word_b,
   input  logic [WORD_BITS-1:0] mask,
   output logic [LEN_W-1:0]     match_acc,
   output logic [LEN_W-1:0]     both_acc,
   output logic [LEN_W-1:0]     either_acc
);

   localparam int CHUNKS = (WORD_BITS + CHUNK_W - 1) / CHUNK_W;
   localparam int SH_W   = CHUNKS * CHUNK_W;

   logic [SH_W-1:0]  a_ff, a_in, b_ff, b_in, m_ff, m_in;
   logic [LEN_W-1:0] match_ff, match_in, both_ff, both_in, either_ff, either_in;
   logic [CHUNK_W-1:0] ca, cb, cm;

   assign ca = a_ff[CHUNK_W-1:0];
   assign cb = b_ff[CHUNK_W-1:0];
   assign cm = m_ff[CHUNK_W-1:0];

   // Word shifters: load masked words, then drop one slice per step
   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      m_in = m_ff;
      if (ctl.load) begin
         a_in = SH_W'(word_a[WORD_BITS-1:0] & mask);
         b_in = SH_W'(word_b[WORD_BITS-1:0] & mask);
         m_in = SH_W'(mask);
      end else if (ctl.step) begin
         a_in = a_ff >> CHUNK_W;
         b_in = b_ff >> CHUNK_W;
         m_in = m_ff >> CHUNK_W;
      end
   end

   // Running counts
   always_comb begin
      match_in  = match_ff;
      both_in   = both_ff;
      either_in = either_ff;
      if (ctl.clear) begin
         match_in  = '0;
         both_in   = '0;
         either_in = '0;
      end else if (ctl.step) begin
         match_in  = match_ff + LEN_W'(pop_chunk(~(ca ^ cb) & cm));
         both_in   = both_ff + LEN_W'(pop_chunk(ca & cb));
         either_in = either_ff + LEN_W'(pop_chunk(ca | cb));
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      m_ff <= m_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff  <= '0;
         both_ff   <= '0;
         either_ff <= '0;
      end else begin
         match_ff  <= match_in;
         both_ff   <= both_in;
         either_ff <= either_in;
      end
   end

   assign match_acc  = match_ff;
   assign both_acc   = both_ff;
   assign either_acc = either_ff;

endmodule

// File: src/bvs_div.sv
// Restoring divider: both count over either count as a Q1.16 fraction, one bit per cycle.
`timescale 1ns / 1ps

module bvs_div
   import bvs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [LEN_W-1:0]   dividend,
   input  logic [LEN_W-1:0]   divisor,
   output logic               busy,
   output logic [RATIO_W-1:0] quotient
);

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [LEN_W:0]       rem_ff, rem_in;
   logic [LEN_W-1:0]     dsr_ff, dsr_in;
   logic [RATIO_W-1:0]   q_ff, q_in;
   logic [LEN_W:0]       diff;
   logic                 ge;

   // Shared compare / subtract
   assign ge   = rem_ff >= {1'b0, dsr_ff};
   assign diff = rem_ff - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_STEPS);
         rem_in  = {1'b0, dividend};
         dsr_in  = divisor;
         q_in    = '0;
      end else if (busy_ff) begin
         // Remainder stays below the divisor after each step, so the shift fits
         rem_in  = (ge ? diff : rem_ff) << 1;
         q_in    = {q_ff[RATIO_W-2:0], ge};
         cnt_in  = cnt_ff - DIV_CNT_W'(1);
         busy_in = (cnt_ff != DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      q_ff   <= q_in;
   end

   assign busy     = busy_ff;
   assign quotient = q_ff;

endmodule

// File: src/binary_vector_similarity.sv
// Binary vector similarity: top level with the word sequencer and response register.
//
// Two bit vectors of vector_bits bits arrive as request pairs of words
// (word_a, word_b), lowest word first, bit 0 first. Bits past the vector
// length in the last word are ignored. After the last word one response
// carries the XNOR match count, the AND and OR counts, the Jaccard ratio
// AND/OR as unsigned Q1.16 (65536 is one) and an empty-union flag (ratio 0).
// Requests use valid/ready; one word is taken at a time and req_ready is low
// while it is processed. Each word goes through an 8-bit popcount slice,
// one slice per cycle, in ST_COUNT. On the last word a restoring divider
// adds one quotient bit per cycle, and the response register is loaded in
// ST_DONE after the ST_START and ST_DIVIDE states, once the register is free.
// The response waits in its own register, so a stalled receiver does not
// stop the next vector's words; only the following response waits for it.
// Reset clears the counts and sets vector_bits to 64; req_ready stays low
// after reset and after each vector_bits write while the derived length
// settles. The register sits at byte address 0 of the APB port.
`timescale 1ns / 1ps

module binary_vector_similarity
   import bvs_pkg::*;
#(
   parameter int WORD_BITS = 64,
   parameter int MAX_WORDS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_payload,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int MAX_LEN = MAX_WORDS * WORD_BITS;
   localparam int POS_W   = $clog2(MAX_LEN + 1);
   localparam int CHUNKS  = (WORD_BITS + CHUNK_W - 1) / CHUNK_W;
   localparam int CNT_W   = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_COUNT  = 5'b00010,
      ST_START  = 5'b00100,
      ST_DIVIDE = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               last_ff, last_in;
   logic [CNT_W-1:0]   step_ff, step_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_ff, rsp_in;

   cfg_info_type        info;
   count_ctl_type       ctl;
   logic [WORD_BITS-1:0] mask;
   logic [REST_W-1:0]   rest_sel;
   logic                req_fire;
   logic                last_word;
   logic                out_free;
   logic [LEN_W-1:0]    match_acc, both_acc, either_acc;
   logic                div_start, div_busy;
   logic [RATIO_W-1:0]  quotient;

   bvs_cfg #(
      .WORD_BITS(WORD_BITS),
      .MAX_WORDS(MAX_WORDS)
   ) u_cfg (
      .clock  (clock),
      .reset  (reset),
      .psel   (psel),
      .penable(penable),
      .pwrite (pwrite),
      .paddr  (paddr),
      .pwdata (pwdata),
      .prdata (prdata),
      .pready (pready),
      .info   (info)
   );

   bvs_count #(
      .WORD_BITS(WORD_BITS)
   ) u_count (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .word_a    (req_payload.word_a),
      .word_b    (req_payload.word_b),
      .mask      (mask),
      .match_acc (match_acc),
      .both_acc  (both_acc),
      .either_acc(either_acc)
   );

   bvs_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(both_acc),
      .divisor (either_acc),
      .busy    (div_busy),
      .quotient(quotient)
   );

   assign req_ready = (state_ff == ST_IDLE) && !info.busy;
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Last word: this word reaches the vector end under the current length
   assign last_word = (int'(pos_ff) + WORD_BITS) >= int'(info.len);

   // Bits kept in the last word; past the end the length was shortened mid-vector
   always_comb begin
      if (int'(pos_ff) < int'(info.len)) begin
         rest_sel = REST_W'(int'(info.len) - int'(pos_ff));
      end else begin
         rest_sel = info.rest;
      end
      if (!last_word || (int'(rest_sel) >= WORD_BITS)) begin
         mask = '1;
      end else begin
         mask = (WORD_BITS'(1) << rest_sel) - WORD_BITS'(1);
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      last_in      = last_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      ctl          = '0;
      div_start    = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               ctl.load = 1'b1;
               last_in  = last_word;
               pos_in   = last_word ? '0 : POS_W'(int'(pos_ff) + WORD_BITS);
               step_in  = '0;
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            ctl.step = 1'b1;
            step_in  = step_ff + CNT_W'(1);
            if (step_ff == CNT_W'(CHUNKS - 1)) begin
               state_in = last_ff ? ST_START : ST_IDLE;
            end
         end
         ST_START: begin
            div_start = 1'b1;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (!div_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hand the result to the response register, then clear the counts
            if (out_free) begin
               rsp_in.match_count   = match_acc;
               rsp_in.both_count    = both_acc;
               rsp_in.either_count  = either_acc;
               rsp_in.empty_union   = (either_acc == '0);
               rsp_in.jaccard_ratio = (either_acc == '0) ? '0 : quotient;
               rsp_valid_in         = 1'b1;
               ctl.clear            = 1'b1;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         last_ff      <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         last_ff      <= last_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// File: src/bvs_checker.sv
// Port-level checks of the binary vector similarity block, bound to its top level.
`timescale 1ns / 1ps
`include "binary_vector_similarity_macros.svh"

module bvs_checker
   import bvs_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input rsp_payload_type       rsp_payload,
   input logic                  psel,
   input logic                  penable,
   input logic                  pwrite,
   input logic [CSR_ADDR_W-1:0] paddr,
   input logic                  pready
);

   logic req_fire;
   logic rsp_stall;
   logic len_write;
   logic flag_ok;
   logic range_ok;

   assign req_fire  = req_valid && req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;

   // Only a write that hits the length register starts the settling window
   assign len_write = psel && penable && pwrite && pready
                      && (paddr[CSR_ADDR_W-1:2] == REG_VECTOR_BITS);

   assign flag_ok  = (rsp_payload.empty_union == (rsp_payload.either_count == '0))
                     && (!rsp_payload.empty_union || (rsp_payload.jaccard_ratio == '0));
   assign range_ok = (rsp_payload.both_count <= rsp_payload.either_count)
                     && (rsp_payload.jaccard_ratio <= 17'd65536);

   // A stalled response holds
   `BVS_ASSERT_NXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_payload), "stalled rsp changed")

   // A taken request keeps the block busy for its popcount cycles
   `BVS_ASSERT_NXT(a_busy_after_req, req_fire, !req_ready, "request taken back to back")

   // A length write holds off requests while the length settles
   `BVS_ASSERT_NXT(a_busy_after_cfg, len_write, !req_ready, "request taken right after a write")

   // Empty flag tracks the union count and forces a zero ratio
   `BVS_ASSERT_IMP(a_empty_flag, rsp_valid, flag_ok, "empty union flag or ratio wrong")

   // Intersection never exceeds union and the ratio never exceeds one
   `BVS_ASSERT_IMP(a_ratio_range, rsp_valid && !rsp_payload.empty_union, range_ok, "out of range")

endmodule

bind binary_vector_similarity bvs_checker u_bvs_checker (.*);
